// ===== sv/shn_pkg.sv =====
`default_nettype none
package shn_pkg;

    localparam int SHN_MAX_POINTS = 64;

    // Shared divider: numerator, denominator and quotient widths.
    localparam int SHN_NUM_W = 37;
    localparam int SHN_DEN_W = 25;
    localparam int SHN_Q_W   = 17;

    typedef struct packed {
        logic [SHN_Q_W-1:0] quot;
        logic               ovf;
    } t_div_res;

endpackage
`default_nettype wire

// ===== sv/shn_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle. The quotient is flagged as overflowed
// when it does not fit in SHN_Q_W bits; the bits are then meaningless.
module shn_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [shn_pkg::SHN_NUM_W-1:0] i_num,
    input  wire logic [shn_pkg::SHN_DEN_W-1:0] i_den,
    output logic                               o_busy,
    output logic                               o_done,
    output shn_pkg::t_div_res                  o_res
);
    localparam int NW = shn_pkg::SHN_NUM_W;
    localparam int DW = shn_pkg::SHN_DEN_W;
    localparam int QW = shn_pkg::SHN_Q_W;
    localparam int SW = DW + QW;
    localparam int CNT_W = $clog2(QW);

    logic [NW-1:0]    r_rem;
    logic [SW-1:0]    r_dsh;
    logic [QW-1:0]    r_q;
    logic             r_ovf;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;
    logic             w_ge;

    assign w_ge = {{(SW-NW){1'b0}}, r_rem} >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(QW - 1);
                r_rem <= i_num;
                r_dsh <= {1'b0, i_den, {(QW-1){1'b0}}};
                r_q   <= '0;
                r_ovf <= {{(SW-NW){1'b0}}, i_num} >= {i_den, {QW{1'b0}}};
            end else if (r_run) begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh[NW-1:0];
                end
                r_q   <= {r_q[QW-2:0], w_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy     = r_run;
    assign o_done     = r_done;
    assign o_res.quot = r_q;
    assign o_res.ovf  = r_ovf;

endmodule
`default_nettype wire

// ===== sv/shape_normalize.sv =====
// Loading accepts one point per cycle. The last point starts the centroid divide,
// then the squared-sum pass over the point memory, the square root, then one divide
// per point emitted on the 17-step shared dividers (x and y in parallel); emission
// waits while the output is held off.
// Reset (synchronous, active low) clears the count, sums and flags; the memory is not cleared.
`default_nettype none
module shape_normalize #(
    parameter int MAX_POINTS = shn_pkg::SHN_MAX_POINTS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // in_x[15:0], in_y[31:16]
    input  wire logic        s_axis_tlast,   // in_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // out_x[15:0], out_y[31:16],
                                             // shape_norm[55:32], overflow[56], zeros
    output logic             m_axis_tlast    // out_last
);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int NW = shn_pkg::SHN_NUM_W;
    localparam int DW = shn_pkg::SHN_DEN_W;
    localparam int QW = shn_pkg::SHN_Q_W;

    typedef enum logic [3:0] {
        ST_LOAD, ST_CGO, ST_CWT, ST_SUM, ST_SQRT,
        ST_ERD, ST_EDIF, ST_EGO, ST_EWT, ST_EOUT
    } t_state;

    t_state r_st;

    logic [31:0] r_mem [MAX_POINTS];
    logic [31:0] r_rdata;
    logic [AW-1:0] w_rd_addr;

    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_idx;
    logic [22:0]    r_sumx, r_sumy;
    logic           r_drop;
    logic [16:0]    r_cx, r_cy;
    logic signed [16:0] r_dx, r_dy;
    logic [33:0]    r_sqx, r_sqy;
    logic           r_p1, r_p2, r_p3;
    logic [39:0]    r_s;
    logic [47:0]    r_sq_rem;
    logic [48:0]    r_sq_res;
    logic [47:0]    r_sq_bit;
    logic [DW-1:0]  r_norm;

    logic           w_accept, w_room;
    logic [48:0]    w_trial;
    logic [DW-1:0]  w_root;
    logic [16:0]    w_magx, w_magy;
    logic           w_start;
    logic [NW-1:0]  w_numx, w_numy;
    logic [DW-1:0]  w_den;
    logic           w_busy_x, w_busy_y, w_done_x, w_done_y;
    shn_pkg::t_div_res w_resx, w_resy;
    logic [15:0]    w_ox, w_oy;
    logic [23:0]    w_nfield;

    function automatic logic [15:0] sat_q(input logic neg, input shn_pkg::t_div_res res);
        logic [16:0] negq;
        negq = -res.quot;
        if (neg) begin
            sat_q = (res.ovf || res.quot > 17'd32768) ? 16'h8000 : negq[15:0];
        end else begin
            sat_q = (res.ovf || res.quot > 17'd32767) ? 16'h7FFF : res.quot[15:0];
        end
    endfunction

    assign s_axis_tready = (r_st == ST_LOAD);
    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_room    = r_count < CW'(MAX_POINTS);
    assign w_rd_addr = r_idx[AW-1:0];

    assign w_trial = r_sq_res + {1'b0, r_sq_bit};
    assign w_root  = ({1'b0, r_sq_rem} > r_sq_res) ? r_sq_res[DW-1:0] + 1'b1
                                                  : r_sq_res[DW-1:0];

    assign w_magx = r_dx[16] ? 17'(-r_dx) : 17'(r_dx);
    assign w_magy = r_dy[16] ? 17'(-r_dy) : 17'(r_dy);

    // The two dividers serve the centroid first, then each emitted point.
    always_comb begin
        w_start = 1'b0;
        w_numx  = '0;
        w_numy  = '0;
        w_den   = r_norm;
        unique case (r_st)
            ST_CGO: begin
                w_start = 1'b1;
                w_den   = DW'(r_count);
                w_numx  = NW'(r_sumx[22] ? 23'(-r_sumx) : r_sumx) + NW'(r_count >> 1);
                w_numy  = NW'(r_sumy[22] ? 23'(-r_sumy) : r_sumy) + NW'(r_count >> 1);
            end
            ST_EGO: begin
                w_start = 1'b1;
                w_numx  = {1'b0, w_magx, 19'b0} + NW'(r_norm >> 1);
                w_numy  = {1'b0, w_magy, 19'b0} + NW'(r_norm >> 1);
            end
            default: begin
            end
        endcase
    end

    shn_div u_div_x (
        .i_clk, .i_rst_n, .i_start(w_start), .i_num(w_numx), .i_den(w_den),
        .o_busy(w_busy_x), .o_done(w_done_x), .o_res(w_resx)
    );
    shn_div u_div_y (
        .i_clk, .i_rst_n, .i_start(w_start), .i_num(w_numy), .i_den(w_den),
        .o_busy(w_busy_y), .o_done(w_done_y), .o_res(w_resy)
    );

    assign w_ox     = sat_q(r_dx[16], w_resx);
    assign w_oy     = sat_q(r_dy[16], w_resy);
    assign w_nfield = r_norm[DW-1] ? 24'hFFFFFF : r_norm[23:0];

    always_ff @(posedge i_clk) begin
        if (w_accept && w_room) begin
            r_mem[r_count[AW-1:0]] <= s_axis_tdata;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st          <= ST_LOAD;
            r_count       <= '0;
            r_idx         <= '0;
            r_sumx        <= '0;
            r_sumy        <= '0;
            r_drop        <= 1'b0;
            r_p1          <= 1'b0;
            r_p2          <= 1'b0;
            r_p3          <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (r_st == ST_EOUT && (!m_axis_tvalid || m_axis_tready)) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            unique case (r_st)
                ST_LOAD: begin
                    if (w_accept) begin
                        if (w_room) begin
                            r_count <= r_count + 1'b1;
                            r_sumx  <= r_sumx + {{7{s_axis_tdata[15]}}, s_axis_tdata[15:0]};
                            r_sumy  <= r_sumy + {{7{s_axis_tdata[31]}}, s_axis_tdata[31:16]};
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_st <= ST_CGO;
                        end
                    end
                end
                ST_CGO: r_st <= ST_CWT;
                ST_CWT: begin
                    if (w_done_x) begin
                        r_cx  <= r_sumx[22] ? -w_resx.quot : w_resx.quot;
                        r_cy  <= r_sumy[22] ? -w_resy.quot : w_resy.quot;
                        r_idx <= '0;
                        r_s   <= '0;
                        r_st  <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    // Read, difference, square and accumulate as a four-stage pipe.
                    r_p1 <= (r_idx != r_count);
                    if (r_idx != r_count) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    r_p2  <= r_p1;
                    r_dx  <= {r_rdata[15], r_rdata[15:0]} - r_cx;
                    r_dy  <= {r_rdata[31], r_rdata[31:16]} - r_cy;
                    r_p3  <= r_p2;
                    r_sqx <= r_dx * r_dx;
                    r_sqy <= r_dy * r_dy;
                    if (r_p3) begin
                        r_s <= r_s + 40'(r_sqx) + 40'(r_sqy);
                    end
                    if (r_idx == r_count && !r_p1 && !r_p2 && !r_p3) begin
                        r_sq_rem <= {r_s[39:0], 8'b0};
                        r_sq_res <= '0;
                        r_sq_bit <= 48'h1 << 46;
                        r_st     <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (r_sq_bit != '0) begin
                        if ({1'b0, r_sq_rem} >= w_trial) begin
                            r_sq_rem <= r_sq_rem - w_trial[47:0];
                            r_sq_res <= (r_sq_res >> 1) + {1'b0, r_sq_bit};
                        end else begin
                            r_sq_res <= r_sq_res >> 1;
                        end
                        r_sq_bit <= r_sq_bit >> 2;
                    end else begin
                        // A zero norm stands in as 256, i.e. 16.0 with the norm's four fraction bits.
                        r_norm <= (w_root == '0) ? DW'(256) : w_root;
                        r_idx  <= '0;
                        r_st   <= ST_ERD;
                    end
                end
                ST_ERD: r_st <= ST_EDIF;
                ST_EDIF: begin
                    r_dx <= {r_rdata[15], r_rdata[15:0]} - r_cx;
                    r_dy <= {r_rdata[31], r_rdata[31:16]} - r_cy;
                    r_st <= ST_EGO;
                end
                ST_EGO: r_st <= ST_EWT;
                ST_EWT: begin
                    if (w_done_x) begin
                        r_st <= ST_EOUT;
                    end
                end
                ST_EOUT: begin
                    if (!m_axis_tvalid || m_axis_tready) begin
                        m_axis_tdata  <= {7'b0, r_drop, w_nfield, w_oy, w_ox};
                        m_axis_tlast  <= (r_idx + 1'b1 == r_count);
                        if (r_idx + 1'b1 == r_count) begin
                            r_count <= '0;
                            r_sumx  <= '0;
                            r_sumy  <= '0;
                            r_drop  <= 1'b0;
                            r_st    <= ST_LOAD;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                            r_st  <= ST_ERD;
                        end
                    end
                end
                default: r_st <= ST_LOAD;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("point count exceeds capacity");
    a_div_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done_x == w_done_y) && (w_busy_x == w_busy_y))
        else $error("dividers out of step");
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_busy_x)
        else $error("divider busy while loading");
    a_sum_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_SUM) |-> (r_idx <= r_count))
        else $error("sum pass index past count");
`endif

endmodule
`default_nettype wire
